// ===== design/bfm_pkg.sv =====
package bfm_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_IMAGE_WIDTH  = 0;
   localparam int unsigned CSR_IMAGE_HEIGHT = 1;
   localparam int unsigned CSR_INDEX_W      = 2;
   localparam int unsigned CSR_DATA_W       = 12;

   // Fixed field widths
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned LEVEL_W = 4;

   // Default geometry limits
   localparam int unsigned MAX_DIMENSION_DEF = 2048;
   localparam int unsigned MAX_LEVELS_DEF    = 12;

   // RGBA pixel, red in the low byte
   typedef logic [4*CHAN_W-1:0] pixel_type;

   // What a cell reports to the sequencer
   typedef struct packed {
      logic      emit;   // next firing yields a result
      pixel_type res;    // the result pixel for the current token
   } cell_status_type;

endpackage

// ===== design/bfm_cell.sv =====
module bfm_cell #(
   parameter int unsigned MAX_DIMENSION = 2048,
   parameter int unsigned MAX_LEVELS    = 12,
   parameter int unsigned LEVEL         = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   restart,
   input  logic [$clog2(MAX_DIMENSION+1)-1:0]     base_width,
   input  logic [$clog2(MAX_DIMENSION+1)-1:0]     base_height,
   input  logic                                   fire,
   input  bfm_pkg::pixel_type                     px,
   output bfm_pkg::cell_status_type               status
);
   import bfm_pkg::*;

   localparam int unsigned DIM_W = $clog2(MAX_DIMENSION+1);
   localparam int unsigned POS_W = $clog2(MAX_DIMENSION);
   localparam int unsigned DEPTH_RAW = MAX_DIMENSION >> (LEVEL+1);
   localparam int unsigned DEPTH = (DEPTH_RAW < 1) ? 1 : DEPTH_RAW;
   localparam int unsigned AW = (DEPTH < 2) ? 1 : $clog2(DEPTH);
   localparam int unsigned SUM_W = CHAN_W + 1;

   logic [DIM_W-1:0] wl, hl, wsh, hsh;
   logic [POS_W-1:0] x_ff, x_in, y_ff, y_in;
   pixel_type        held_ff, held_in;
   logic [4*SUM_W-1:0] top_mem [DEPTH];
   logic [4*SUM_W-1:0] top_rd_ff;
   logic [4*SUM_W-1:0] pair;
   logic [POS_W-1:0] dx_full;
   logic [AW-1:0]    dx;
   logic             active, w1, h1, have, last_col, last_row, mem_we;
   logic [SUM_W:0]   tot;
   logic             emit_now;
   pixel_type        res_px;

   // Level geometry: base size halved per level, floored at one
   assign wsh = base_width >> LEVEL;
   assign hsh = base_height >> LEVEL;
   assign wl  = (wsh == '0) ? DIM_W'(1) : wsh;
   assign hl  = (hsh == '0) ? DIM_W'(1) : hsh;
   assign active = (wl > DIM_W'(1)) || (hl > DIM_W'(1));
   assign w1 = (wl == DIM_W'(1));
   assign h1 = (hl == DIM_W'(1));

   assign last_col = (DIM_W'(x_ff) + DIM_W'(1) == wl);
   assign last_row = (DIM_W'(y_ff) + DIM_W'(1) == hl);
   assign have = w1 || x_ff[0];
   assign dx_full = x_ff >> 1;
   assign dx = dx_full[AW-1:0];

   // Horizontal pair sums and the vertical combine
   always_comb begin
      pair = '0;
      res_px = '0;
      tot = '0;
      for (int c = 0; c < 4; c++) begin
         if (w1) begin
            pair[c*SUM_W +: SUM_W] = {px[c*CHAN_W +: CHAN_W], 1'b0};
         end else begin
            pair[c*SUM_W +: SUM_W] = SUM_W'(held_ff[c*CHAN_W +: CHAN_W])
                                   + SUM_W'(px[c*CHAN_W +: CHAN_W]);
         end
         if (h1) begin
            res_px[c*CHAN_W +: CHAN_W] = pair[c*SUM_W+1 +: CHAN_W];
         end else begin
            tot = (SUM_W+1)'(top_rd_ff[c*SUM_W +: SUM_W])
                + (SUM_W+1)'(pair[c*SUM_W +: SUM_W]);
            res_px[c*CHAN_W +: CHAN_W] = tot[SUM_W:2];
         end
      end
   end

   assign emit_now = active && have && (h1 || y_ff[0]);
   assign status = {emit_now, res_px};

   // Position and held pixel update on a firing
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      held_in = held_ff;
      mem_we = 1'b0;
      if (fire && active) begin
         if (last_col) begin
            x_in = '0;
            y_in = last_row ? '0 : y_ff + POS_W'(1);
         end else begin
            x_in = x_ff + POS_W'(1);
         end
         if (!w1 && !x_ff[0] && !last_col) begin
            held_in = px;
         end
         mem_we = have && !h1 && !y_ff[0] && !last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         x_ff <= '0;
         y_ff <= '0;
         held_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         held_ff <= held_in;
      end
   end

   // Upper pair store; read ahead at the current column pair
   always_ff @(posedge clock) begin
      if (mem_we) begin
         top_mem[dx] <= pair;
      end
      top_rd_ff <= top_mem[dx];
   end

endmodule

// ===== design/box_filter_mip_chain_top.sv =====
// 2x2 box filter mip chain generator.
// Input channel req_*: one RGBA8 base pixel per beat, raster order.
// Result channel rsp_*: for each input beat, the level 0 echo first, then
// every deeper level pixel it completes in ascending level order;
// rsp_last_of_item marks the final result of that input pixel.
// csr_*: write image_width (index 0) and image_height (index 1). Any write
// restarts the frame at every level; write only while the block is idle.
// Operation: the input beat loads the level 0 echo and starts a token that
// visits the level cells one per cycle while the output register is not held
// by a stall; each visited cell updates its position and passes on any pixel
// it completes. The walk ends at the first cell that completes nothing, or
// after the deepest cell. A new input is taken only after the walk ends.
// The level 0 echo is registered and shows in the cycle after the input beat.
// Each level cell keeps its position, its pending left pixel and a memory of
// upper-row pair sums, read through a register ahead of use.
// Reset: synchronous, sets both dimensions to 1 and clears all positions.
// A stalled result holds in the output register and stops the chain; the
// input stays stalled until the current pixel's results are all delivered.
module box_filter_mip_chain_top #(
   parameter int unsigned MAX_DIMENSION = bfm_pkg::MAX_DIMENSION_DEF,
   parameter int unsigned MAX_LEVELS    = bfm_pkg::MAX_LEVELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bfm_pkg::CHAN_W-1:0]        req_red_in,
   input  logic [bfm_pkg::CHAN_W-1:0]        req_green_in,
   input  logic [bfm_pkg::CHAN_W-1:0]        req_blue_in,
   input  logic [bfm_pkg::CHAN_W-1:0]        req_alpha_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bfm_pkg::LEVEL_W-1:0]       rsp_level,
   output logic [bfm_pkg::CHAN_W-1:0]        rsp_red_out,
   output logic [bfm_pkg::CHAN_W-1:0]        rsp_green_out,
   output logic [bfm_pkg::CHAN_W-1:0]        rsp_blue_out,
   output logic [bfm_pkg::CHAN_W-1:0]        rsp_alpha_out,
   output logic                              rsp_last_of_item,
   input  logic                              csr_we,
   input  logic [bfm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bfm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bfm_pkg::*;

   localparam int unsigned DIM_W = $clog2(MAX_DIMENSION+1);
   localparam int unsigned NCELL = MAX_LEVELS - 1;
   localparam int unsigned TOK_W = (NCELL < 2) ? 1 : $clog2(NCELL);

   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [DIM_W-1:0]      cw, ch;
   cell_status_type       status [NCELL];
   logic [NCELL-1:0]      cell_fire;

   logic                  tok_valid_ff, tok_valid_in;
   logic [TOK_W-1:0]      tok_ff, tok_in;
   pixel_type             px_ff, px_in;
   logic                  out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0]    out_level_ff, out_level_in;
   pixel_type             out_px_ff, out_px_in;
   logic                  out_last_ff, out_last_in;
   logic                  slot_free, accept, fire, nxt_emit;
   cell_status_type       cur;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CSR_DATA_W'(1);
         height_ff <= CSR_DATA_W'(1);
      end else if (csr_we) begin
         if (csr_index == CSR_INDEX_W'(CSR_IMAGE_WIDTH)) width_ff <= csr_wdata;
         if (csr_index == CSR_INDEX_W'(CSR_IMAGE_HEIGHT)) height_ff <= csr_wdata;
      end
   end

   // Clamp dimensions to 1..MAX_DIMENSION
   always_comb begin
      if (width_ff == '0) cw = DIM_W'(1);
      else if (32'(width_ff) > MAX_DIMENSION) cw = DIM_W'(MAX_DIMENSION);
      else cw = DIM_W'(width_ff);
      if (height_ff == '0) ch = DIM_W'(1);
      else if (32'(height_ff) > MAX_DIMENSION) ch = DIM_W'(MAX_DIMENSION);
      else ch = DIM_W'(height_ff);
   end

   // Level cells
   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      assign cell_fire[g] = fire && (tok_ff == TOK_W'(g));
      bfm_cell #(
         .MAX_DIMENSION (MAX_DIMENSION),
         .MAX_LEVELS    (MAX_LEVELS),
         .LEVEL         (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .restart     (csr_we),
         .base_width  (cw),
         .base_height (ch),
         .fire        (cell_fire[g]),
         .px          (px_ff),
         .status      (status[g])
      );
   end

   // Token sequencer
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign accept = req_valid && !tok_valid_ff && slot_free;
   assign fire = tok_valid_ff && slot_free;
   assign req_stall = tok_valid_ff || !slot_free;

   always_comb begin
      cur = status[tok_ff];
      nxt_emit = 1'b0;
      if (32'(tok_ff) + 1 < NCELL) begin
         nxt_emit = status[TOK_W'(32'(tok_ff) + 1)].emit;
      end
   end

   // every cell the token reaches must fire, whether it emits or not
   always_comb begin
      tok_valid_in = tok_valid_ff;
      tok_in = tok_ff;
      px_in = px_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_level_in = out_level_ff;
      out_px_in = out_px_ff;
      out_last_in = out_last_ff;
      if (accept) begin
         out_valid_in = 1'b1;
         out_level_in = '0;
         out_px_in = {req_alpha_in, req_blue_in, req_green_in, req_red_in};
         out_last_in = !status[0].emit;
         px_in = out_px_in;
         tok_in = '0;
         tok_valid_in = 1'b1;
      end else if (fire) begin
         if (cur.emit) begin
            out_valid_in = 1'b1;
            out_level_in = LEVEL_W'(32'(tok_ff) + 1);
            out_px_in = cur.res;
            out_last_in = !nxt_emit;
            px_in = cur.res;
            tok_in = TOK_W'(32'(tok_ff) + 1);
            tok_valid_in = (32'(tok_ff) + 1 < NCELL);
         end else begin
            tok_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         tok_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
         tok_ff <= tok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      out_level_ff <= out_level_in;
      out_px_ff <= out_px_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_level = out_level_ff;
   assign rsp_red_out = out_px_ff[0*CHAN_W +: CHAN_W];
   assign rsp_green_out = out_px_ff[1*CHAN_W +: CHAN_W];
   assign rsp_blue_out = out_px_ff[2*CHAN_W +: CHAN_W];
   assign rsp_alpha_out = out_px_ff[3*CHAN_W +: CHAN_W];
   assign rsp_last_of_item = out_last_ff;

endmodule

// ===== dv/box_filter_mip_chain_checker.sv =====
module box_filter_mip_chain_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [bfm_pkg::CHAN_W-1:0]        req_red_in,
   input  logic [bfm_pkg::CHAN_W-1:0]        req_green_in,
   input  logic [bfm_pkg::CHAN_W-1:0]        req_blue_in,
   input  logic [bfm_pkg::CHAN_W-1:0]        req_alpha_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [bfm_pkg::LEVEL_W-1:0]       rsp_level,
   input  logic [bfm_pkg::CHAN_W-1:0]        rsp_red_out,
   input  logic [bfm_pkg::CHAN_W-1:0]        rsp_green_out,
   input  logic [bfm_pkg::CHAN_W-1:0]        rsp_blue_out,
   input  logic [bfm_pkg::CHAN_W-1:0]        rsp_alpha_out,
   input  logic                              rsp_last_of_item,
   input  logic                              csr_we,
   input  logic [bfm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bfm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                errors,
   output int                                pending
);
   import bfm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM  = MAX_DIMENSION_DEF;
   localparam int MAX_LVL  = MAX_LEVELS_DEF;
   localparam int SUM_DEPTH = MAX_DIM + MAX_LVL;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      pixel_type          px;
      logic               last;
   } mip_beat_type;

   mip_beat_type mip_expected[$];

   logic [11:0] width_reg, height_reg;
   int          lvl_wd [MAX_LVL];
   int          lvl_ht [MAX_LVL];
   int          lvl_ofs[MAX_LVL];
   int          lvl_num;
   int          col_pos[MAX_LVL];
   int          row_pos[MAX_LVL];
   pixel_type   left_px[MAX_LVL];
   logic [35:0] upper_sums[SUM_DEPTH];

   function automatic int clamp_dim(int d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
   endfunction

   function automatic int half_dim(int d);
      return (d / 2 != 0) ? d / 2 : 1;
   endfunction

   // level sizes and sum-memory regions from the two registers
   task automatic rebuild_levels();
      int w, h, ofs;
      w = clamp_dim(int'(width_reg));
      h = clamp_dim(int'(height_reg));
      ofs = 0;
      lvl_num = 0;
      forever begin
         lvl_wd[lvl_num]  = w;
         lvl_ht[lvl_num]  = h;
         lvl_ofs[lvl_num] = ofs;
         lvl_num++;
         if ((w <= 1 && h <= 1) || lvl_num >= MAX_LVL) break;
         ofs += half_dim(w);
         w = half_dim(w);
         h = half_dim(h);
      end
   endtask

   task automatic restart_levels();
      for (int i = 0; i < MAX_LVL; i++) begin
         col_pos[i] = 0;
         row_pos[i] = 0;
         left_px[i] = '0;
      end
   endtask

   // walk one base pixel down the chain, queueing every pixel it completes
   task automatic predict_mips(pixel_type base_px);
      pixel_type   px, res;
      logic [35:0] pair;
      int          w, h, x, y, dx, idx, s;
      bit          have;
      mip_beat_type b;
      px = base_px;
      b.level = '0;
      b.px = px;
      b.last = 1'b0;
      mip_expected.insert(mip_expected.size(), b);
      for (int lv = 0; lv + 1 < lvl_num; lv++) begin
         w = lvl_wd[lv];
         h = lvl_ht[lv];
         x = (col_pos[lv] < w) ? col_pos[lv] : 0;
         y = (row_pos[lv] < h) ? row_pos[lv] : 0;
         col_pos[lv] = x + 1;
         row_pos[lv] = y;
         if (x + 1 >= w) begin
            col_pos[lv] = 0;
            row_pos[lv] = (y + 1 >= h) ? 0 : y + 1;
         end
         have = 1'b0;
         dx = 0;
         pair = '0;
         if (w == 1) begin
            for (int c = 0; c < 4; c++) pair[9*c +: 9] = {px[8*c +: 8], 1'b0};
            have = 1'b1;
         end else if (x % 2 == 1) begin
            for (int c = 0; c < 4; c++)
               pair[9*c +: 9] = 9'(left_px[lv][8*c +: 8]) + 9'(px[8*c +: 8]);
            dx = x / 2;
            have = 1'b1;
         end else if (x + 1 < w) begin
            left_px[lv] = px;
         end
         if (!have) break;
         idx = lvl_ofs[lv] + dx;
         if (h == 1) begin
            for (int c = 0; c < 4; c++) res[8*c +: 8] = pair[9*c+1 +: 8];
         end else if (y % 2 == 1) begin
            for (int c = 0; c < 4; c++) begin
               s = int'(pair[9*c +: 9]);
               if (idx < SUM_DEPTH) s += int'(upper_sums[idx][9*c +: 9]);
               res[8*c +: 8] = 8'(s / 4);
            end
         end else begin
            if (y + 1 < h && idx < SUM_DEPTH) upper_sums[idx] = pair;
            break;
         end
         px = res;
         b.level = LEVEL_W'(lv + 1);
         b.px = px;
         mip_expected.insert(mip_expected.size(), b);
      end
      mip_expected[$].last = 1'b1;
   endtask

   // watch all three ports each edge
   always @(posedge clock) begin
      mip_beat_type exp_b, got_b;
      if (reset) begin
         width_reg  = 12'd1;
         height_reg = 12'd1;
         restart_levels();
         for (int i = 0; i < SUM_DEPTH; i++) upper_sums[i] = '0;
         rebuild_levels();
         mip_expected.delete();
         errors = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_wdata;
            else if (csr_index == CSR_IMAGE_HEIGHT) height_reg = csr_wdata;
            rebuild_levels();
            restart_levels();
         end
         if (req_valid && !req_stall)
            predict_mips({req_alpha_in, req_blue_in, req_green_in, req_red_in});
         if (rsp_valid && !rsp_stall) begin
            got_b.level = rsp_level;
            got_b.px = {rsp_alpha_out, rsp_blue_out, rsp_green_out, rsp_red_out};
            got_b.last = rsp_last_of_item;
            if (mip_expected.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected beat: level %0d px %h last %b",
                           got_b.level, got_b.px, got_b.last);
            end else begin
               exp_b = mip_expected.pop_front();
               if (got_b !== exp_b) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: exp level %0d px %h last %b, ",
                               "got level %0d px %h last %b"},
                              exp_b.level, exp_b.px, exp_b.last,
                              got_b.level, got_b.px, got_b.last);
               end
            end
         end
      end
      pending = mip_expected.size();
   end

endmodule

// ===== dv/tb.sv =====
module tb;
   import bfm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_GAP     = 17;
   localparam int CSR_UNUSED_INDEX = 3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHAN_W-1:0]      req_red_in = '0, req_green_in = '0;
   logic [CHAN_W-1:0]      req_blue_in = '0, req_alpha_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]     rsp_level;
   logic [CHAN_W-1:0]      rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   logic                   rsp_last_of_item;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int   errors, pending;
   int   cycles = 0;
   int   rsp_hold = 0;
   int   pixels_sent = 0;
   bit   no_idle = 0;
   logic req_stall_q = 1'b1, rsp_valid_q = 1'b0;

   box_filter_mip_chain_top i_dut (.*);

   box_filter_mip_chain_checker i_chk (.*);

   always #1 clock = ~clock;

   // handshake signals as they stood before the coming edge
   always @(negedge clock) begin
      req_stall_q <= req_stall;
      rsp_valid_q <= rsp_valid;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: hold off a random number of cycles after each beat
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid_q && !rsp_stall) begin
         n = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         rsp_stall <= (n != 0);
         rsp_hold  <= n;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_stall <= (rsp_hold > 1);
      end
   end

   task automatic send_pixel(pixel_type px);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= px[7:0];
      req_green_in <= px[15:8];
      req_blue_in  <= px[23:16];
      req_alpha_in <= px[31:24];
      do @(posedge clock); while (req_stall_q);
      pixels_sent++;
   endtask

   // drain, then reprogram the frame geometry
   task automatic set_geometry(int w, int h, bit extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_INDEX_W'(CSR_IMAGE_WIDTH);
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_INDEX_W'(CSR_IMAGE_HEIGHT);
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      if (extra) begin
         csr_index <= CSR_INDEX_W'(CSR_UNUSED_INDEX);
         csr_wdata <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      no_idle = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_random(int n);
      repeat (n) send_pixel($urandom);
   endtask

   initial begin
      int w, h, n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry is 1x1: every pixel is its own chain
      send_pixel('0);
      send_pixel('1);
      send_pixel($urandom);
      // 2x2 with extreme channel values
      set_geometry(2, 2, 0);
      send_pixel('1); send_pixel('1); send_pixel('1); send_pixel(32'hFFFF_FFFE);
      send_pixel('0); send_pixel('1); send_pixel(32'h00FF_00FF); send_pixel('1);
      // zero dimensions act as one
      set_geometry(0, 0, 1);
      send_random(2);
      // odd sizes drop the trailing row and column, single column and row
      set_geometry(3, 3, 0);
      send_random(9);
      set_geometry(1, 4, 0);
      send_random(4);
      set_geometry(4, 1, 1);
      send_random(4);
      // oversize clamps to the maximum
      set_geometry(4095, 2, 0);
      send_random(40);
      set_geometry(2048, 2048, 0);
      send_random(20);

      // random geometry, mostly whole frames so the deep levels fill
      while (pixels_sent < 180) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 9);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 9);
         n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 2)
             + $urandom_range(0, 3);
         if (n > 60) n = 60;
         set_geometry(w, h, $urandom_range(0, 4) == 0);
         send_random(n);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== box_filter_mip_chain_top.f =====
design/bfm_pkg.sv
design/bfm_cell.sv
design/box_filter_mip_chain_top.sv
dv/box_filter_mip_chain_checker.sv
dv/tb.sv
